// ===== design/srwb_pkg.sv =====
package srwb_pkg;

	localparam int SEQ_W    = 32;
	localparam int PKT_W    = 64;
	localparam int FUNC_W   = 3;
	localparam int CFG_W    = 6;
	localparam int MOD_STEP = 8;

	localparam int DEF_MAX_WINDOW  = 32;
	localparam int DEF_PACKET_BITS = 64;

	localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(8);

	localparam logic [FUNC_W-1:0] FUNC_STORE  = FUNC_W'(0);
	localparam logic [FUNC_W-1:0] FUNC_READ   = FUNC_W'(1);
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = FUNC_W'(2);
	localparam logic [FUNC_W-1:0] FUNC_SLIDE  = FUNC_W'(3);
	localparam logic [FUNC_W-1:0] FUNC_SETCUR = FUNC_W'(4);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SEQ_W-1:0]  seq_num;
		logic [PKT_W-1:0]  packet_in;
	} srwb_req_t;

	typedef struct packed {
		logic [PKT_W-1:0] packet_out;
		logic             slot_valid;
		logic             in_window;
		logic             closed;
		logic             all_full;
		logic             all_empty;
		logic [SEQ_W-1:0] lower_edge_out;
		logic [SEQ_W-1:0] current_out;
	} srwb_rsp_t;

	typedef struct packed {
		logic load;
		logic mod_go;
		logic mod_sel_lower;
		logic slot_save;
		logic exec;
		logic resp;
	} srwb_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic is_slide;
	} srwb_stat_t;

endpackage

// ===== design/srwb_mod.sv =====
module srwb_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [srwb_pkg::SEQ_W-1:0] dividend,
	input  logic [srwb_pkg::CFG_W-1:0] divisor,
	output logic [srwb_pkg::CFG_W-1:0] rem,
	output logic                       done
);
	import srwb_pkg::*;

	localparam int MOD_CYC = SEQ_W / MOD_STEP;
	localparam int CNT_W   = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

	logic [CFG_W-1:0] rem_q, rem_nx;
	logic [SEQ_W-1:0] dvd_q, dvd_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	// several restoring steps per cycle, remainder stays below the divisor
	always_comb begin
		logic [CFG_W-1:0] r;
		logic [SEQ_W-1:0] d;
		logic [CFG_W:0]   t;
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < MOD_STEP; i++) begin
			t = {r, d[SEQ_W-1]};
			d = {d[SEQ_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[CFG_W-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MOD_CYC - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== design/srwb_ctrl.sv =====
module srwb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  srwb_pkg::srwb_stat_t stat,
	output srwb_pkg::srwb_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);
	import srwb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SLOT = 5'b00010,
		ST_LOW  = 5'b00100,
		ST_EXEC = 5'b01000,
		ST_RESP = 5'b10000
	} state_t;

	state_t state_q, state_nx;
	logic   done_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					cmd.mod_go = 1'b1;
					state_nx   = ST_SLOT;
				end
			end
			ST_SLOT: begin
				if (stat.mod_done) begin
					cmd.slot_save = 1'b1;
					if (stat.is_slide) begin
						// second pass for the slot of the old lower edge
						cmd.mod_go        = 1'b1;
						cmd.mod_sel_lower = 1'b1;
						state_nx          = ST_LOW;
					end else begin
						state_nx = ST_EXEC;
					end
				end
			end
			ST_LOW: begin
				if (stat.mod_done) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = ST_RESP;
			end
			ST_RESP: begin
				cmd.resp = 1'b1;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= cmd.resp;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== design/srwb_dp.sv =====
module srwb_dp #(
	parameter int MAX_WINDOW  = srwb_pkg::DEF_MAX_WINDOW,
	parameter int PACKET_BITS = srwb_pkg::DEF_PACKET_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srwb_pkg::srwb_req_t        req,
	input  srwb_pkg::srwb_cmd_t        cmd,
	output srwb_pkg::srwb_stat_t       stat,
	input  logic                       cfg_we,
	input  logic [srwb_pkg::CFG_W-1:0] cfg_data,
	output srwb_pkg::srwb_rsp_t        rsp
);
	import srwb_pkg::*;

	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int DEPTH   = (MAX_WINDOW < CFG_MAX) ? MAX_WINDOW : CFG_MAX;
	localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]       ws_q;
	logic [CFG_W-1:0]       size;
	srwb_req_t              req_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SEQ_W-1:0]       lower_q;
	logic [SEQ_W-1:0]       cur_q;
	logic [DEPTH-1:0]       valid_q;
	logic [DEPTH-1:0]       in_use;
	logic [DEPTH-1:0]       clear_mask;
	logic                   was_valid_q;
	logic [PACKET_BITS-1:0] mem [DEPTH];
	logic [PACKET_BITS-1:0] rd_q;
	logic [SEQ_W-1:0]       mod_dvd;
	logic [CFG_W-1:0]       mod_rem;
	logic                   mod_done;
	logic [SEQ_W-1:0]       slide_len;
	logic                   fwd_slide;
	logic                   long_slide;
	logic [SEQ_W:0]         upper;
	srwb_rsp_t              rsp_q;

	// window size held to the range 1 .. DEPTH
	always_comb begin
		if (ws_q == '0) begin
			size = CFG_W'(1);
		end else if (ws_q > CFG_W'(DEPTH)) begin
			size = CFG_W'(DEPTH);
		end else begin
			size = ws_q;
		end
	end

	assign mod_dvd = cmd.mod_sel_lower ? (lower_q - SEQ_W'(1)) : (req.seq_num - SEQ_W'(1));

	srwb_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.mod_go),
		.dividend (mod_dvd),
		.divisor  (size),
		.rem      (mod_rem),
		.done     (mod_done)
	);

	assign stat.mod_done = mod_done;
	assign stat.is_slide = (req_q.func == FUNC_SLIDE);

	assign fwd_slide  = (req_q.seq_num > lower_q);
	assign slide_len  = req_q.seq_num - lower_q;
	assign long_slide = (slide_len >= SEQ_W'(size));

	// slots passed over by a slide, counted from the slot of the old lower edge
	always_comb begin
		logic [CFG_W:0] jj;
		logic [CFG_W:0] st;
		logic [CFG_W:0] off;
		for (int j = 0; j < DEPTH; j++) begin
			jj = (CFG_W+1)'(j);
			st = {1'b0, mod_rem};
			if (jj >= st) begin
				off = jj - st;
			end else begin
				off = jj + {1'b0, size} - st;
			end
			in_use[j]     = (CFG_W'(j) < size);
			clear_mask[j] = in_use[j] && fwd_slide
				&& (long_slide || (SEQ_W'(off) < slide_len));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= RESET_SIZE;
			lower_q <= SEQ_W'(1);
			cur_q   <= SEQ_W'(1);
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (req_q.func)
					FUNC_STORE: begin
						valid_q[slot_q] <= 1'b1;
					end
					FUNC_REMOVE: begin
						valid_q[slot_q] <= 1'b0;
					end
					FUNC_SLIDE: begin
						valid_q <= valid_q & ~clear_mask;
						lower_q <= req_q.seq_num;
						if (cur_q < req_q.seq_num) begin
							cur_q <= req_q.seq_num;
						end
					end
					FUNC_SETCUR: begin
						cur_q <= req_q.seq_num;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.slot_save) begin
			slot_q <= mod_rem[SLOT_W-1:0];
		end
		if (cmd.exec) begin
			was_valid_q <= valid_q[slot_q];
			rd_q        <= mem[slot_q];
			if (req_q.func == FUNC_STORE) begin
				mem[slot_q] <= req_q.packet_in[PACKET_BITS-1:0];
			end
		end
	end

	assign upper = {1'b0, lower_q} + (SEQ_W+1)'(size) - (SEQ_W+1)'(1);

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			if (req_q.func == FUNC_READ || req_q.func == FUNC_REMOVE) begin
				rsp_q.packet_out <= PKT_W'(rd_q);
			end else begin
				rsp_q.packet_out <= '0;
			end
			rsp_q.slot_valid     <= was_valid_q;
			rsp_q.in_window      <= (req_q.seq_num >= lower_q)
				&& ({1'b0, req_q.seq_num} <= upper);
			rsp_q.closed         <= ({1'b0, cur_q} > upper);
			rsp_q.all_full       <= &(valid_q | ~in_use);
			rsp_q.all_empty      <= ~|(valid_q & in_use);
			rsp_q.lower_edge_out <= lower_q;
			rsp_q.current_out    <= cur_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== design/selective_repeat_window_buffer_unit.sv =====
// sliding-window packet store for selective-repeat transfer
// command channel: req carries func, seq_num and packet_in; an item is taken
// on a clock edge with start high and busy low, busy stays high until the
// result has been registered
// result channel: rsp is valid for exactly one cycle while done is high; the
// receiver cannot hold it off, so the block never stalls on its output
// config channel: cfg_data is the window size, written when cfg_valid and
// cfg_ready are both high; cfg_ready is low while an item is in flight
// slot index: (seq-1) mod size comes from a shared remainder unit that retires
// 8 dividend bits a cycle; store, read, remove, set current and unused codes
// take one pass, a slide takes a second pass for the old lower edge slot; the
// item is then executed and its result registered, and a new item can be taken
// in the done cycle, not while the previous item is still in flight
// reset: lower edge and current pointer go to 1, window size to 8, all slot
// valid bits clear; packet words are not cleared
module selective_repeat_window_buffer_unit #(
	parameter int MAX_WINDOW  = srwb_pkg::DEF_MAX_WINDOW,
	parameter int PACKET_BITS = srwb_pkg::DEF_PACKET_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  srwb_pkg::srwb_req_t        req,
	output logic                       done,
	output srwb_pkg::srwb_rsp_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [srwb_pkg::CFG_W-1:0] cfg_data
);
	import srwb_pkg::*;

	srwb_cmd_t  cmd;
	srwb_stat_t stat;

	assign cfg_ready = !busy;

	srwb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	srwb_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.PACKET_BITS (PACKET_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

endmodule

// ===== sim/srwb_window_checker.sv =====
`timescale 1ns / 1ps
module srwb_window_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  srwb_pkg::srwb_req_t        req,
	input  logic                       done,
	input  srwb_pkg::srwb_rsp_t        rsp,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [srwb_pkg::CFG_W-1:0] cfg_data,
	output int                         pending,
	output int                         fail_count
);
	import srwb_pkg::*;

	logic [CFG_W-1:0] size_reg;
	logic [SEQ_W-1:0] lower_q;
	logic [SEQ_W-1:0] current_q;
	logic             slot_ok [DEF_MAX_WINDOW];
	logic [PKT_W-1:0] slot_word [DEF_MAX_WINDOW];
	srwb_rsp_t        predicted_status [$];
	srwb_rsp_t        want;
	int               fails;

	function automatic int unsigned slot_count();
		if (size_reg == 0) return 1;
		if (size_reg > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
		return size_reg;
	endfunction

	// applies one item to the window copy and returns the status it reports
	function automatic srwb_rsp_t window_step(srwb_req_t r);
		int unsigned      n;
		int unsigned      slot;
		int unsigned      k;
		logic [SEQ_W-1:0] span;
		logic [SEQ_W:0]   upper;
		logic             full;
		logic             empty;
		srwb_rsp_t        o;
		n = slot_count();
		slot = (r.seq_num - 32'd1) % n;
		o = '0;
		o.slot_valid = slot_ok[slot];
		case (r.func)
			FUNC_STORE: begin
				slot_word[slot] = r.packet_in;
				slot_ok[slot] = 1'b1;
			end
			FUNC_READ: o.packet_out = slot_word[slot];
			FUNC_REMOVE: begin
				o.packet_out = slot_word[slot];
				slot_ok[slot] = 1'b0;
			end
			FUNC_SLIDE: begin
				// a slide past n or more numbers touches every slot anyway
				if (r.seq_num > lower_q) begin
					span = r.seq_num - lower_q;
					for (k = 0; k < n && k < span; k++)
						slot_ok[(lower_q + k - 32'd1) % n] = 1'b0;
				end
				lower_q = r.seq_num;
				if (current_q < lower_q) current_q = lower_q;
			end
			FUNC_SETCUR: current_q = r.seq_num;
			default: ;
		endcase
		upper = {1'b0, lower_q} + (SEQ_W+1)'(n) - 1'b1;
		full = 1'b1;
		empty = 1'b1;
		for (k = 0; k < n; k++) begin
			if (slot_ok[k]) empty = 1'b0;
			else full = 1'b0;
		end
		o.in_window = (r.seq_num >= lower_q) && ({1'b0, r.seq_num} <= upper);
		o.closed = {1'b0, current_q} > upper;
		o.all_full = full;
		o.all_empty = empty;
		o.lower_edge_out = lower_q;
		o.current_out = current_q;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = RESET_SIZE;
			lower_q = 1;
			current_q = 1;
			foreach (slot_ok[i]) slot_ok[i] = 1'b0;
			predicted_status.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (predicted_status.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
					fails++;
				end else begin
					want = predicted_status.pop_front();
					check_field("packet_out", want.packet_out, rsp.packet_out);
					check_field("slot_valid", want.slot_valid, rsp.slot_valid);
					check_field("in_window", want.in_window, rsp.in_window);
					check_field("closed", want.closed, rsp.closed);
					check_field("all_full", want.all_full, rsp.all_full);
					check_field("all_empty", want.all_empty, rsp.all_empty);
					check_field("lower_edge_out", want.lower_edge_out, rsp.lower_edge_out);
					check_field("current_out", want.current_out, rsp.current_out);
				end
			end
			if (cfg_valid && cfg_ready) size_reg = cfg_data;
			if (start && !busy) predicted_status.push_back(window_step(req));
			pending <= predicted_status.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== sim/tb_selective_repeat_window_buffer_unit.sv =====
`timescale 1ns / 1ps
module tb_selective_repeat_window_buffer_unit;
	import srwb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_W'(5);
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = FUNC_W'(7);

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	srwb_req_t        req = '0;
	logic             done;
	srwb_rsp_t        rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	int               pending;
	int               fail_count;
	int               cycle_cnt = 0;

	// stimulus side view of the window, enough to aim items
	logic [CFG_W-1:0] size_now = RESET_SIZE;
	logic [SEQ_W-1:0] lower_seq = 1;
	logic             stored [DEF_MAX_WINDOW] = '{default: 1'b0};
	logic             no_gaps = 1'b0;

	always #2 clk = ~clk;

	selective_repeat_window_buffer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	srwb_window_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	function automatic int unsigned slots_in_use();
		if (size_now == 0) return 1;
		if (size_now > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
		return size_now;
	endfunction

	function automatic int pick_stored(int unsigned n);
		int cand [$];
		for (int i = 0; i < n; i++)
			if (stored[i]) cand.push_back(i);
		if (cand.size() == 0) return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// sequence number in the same group of n numbers as s (one group lower on overflow) whose slot is w
	function automatic logic [SEQ_W-1:0] aim_at_stored(logic [SEQ_W-1:0] s, int unsigned w,
			int unsigned n);
		logic [63:0] m;
		m = 64'(s - 32'd1);
		m = m - (m % n) + w;
		if (m > 64'hFFFF_FFFF) m = m - n;
		return 32'(m + 64'd1);
	endfunction

	task automatic issue(input logic [FUNC_W-1:0] f, input logic [SEQ_W-1:0] s,
			input logic [PKT_W-1:0] p);
		int unsigned n;
		int          w;
		int unsigned gap;
		n = slots_in_use();
		// never read a slot that holds no packet yet
		if ((f == FUNC_READ || f == FUNC_REMOVE) && !stored[(s - 32'd1) % n]) begin
			w = pick_stored(n);
			if (w < 0) f = FUNC_STORE;
			else s = aim_at_stored(s, w, n);
		end
		if (f == FUNC_STORE) stored[(s - 32'd1) % n] = 1'b1;
		if (f == FUNC_SLIDE) lower_seq = s;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		req = '{func: f, seq_num: s, packet_in: p};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk) start = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk) cfg_valid = 1'b0;
		size_now = v;
	endtask

	task automatic directed_items();
		issue(FUNC_STORE, 1, '0);
		issue(FUNC_STORE, 8, '1);
		issue(FUNC_READ, 1, '0);
		// same slot as 1 but past the upper edge
		issue(FUNC_READ, 9, '0);
		issue(FUNC_REMOVE, 8, '0);
		// sequence zero wraps to the top slot
		issue(FUNC_STORE, 0, {$urandom, $urandom});
		issue(FUNC_READ, 0, '0);
		issue(FUNC_STORE, '1, {$urandom, $urandom});
		issue(FUNC_SETCUR, 20, '0);
		for (int c = FUNC_SPARE_LO; c <= FUNC_SPARE_HI; c++)
			issue(FUNC_W'(c), $urandom, {$urandom, $urandom});
		issue(FUNC_SLIDE, 4, '0);
		// backward slide
		issue(FUNC_SLIDE, 2, '0);
		for (int s = 2; s <= 9; s++)
			issue(FUNC_STORE, s, {$urandom, $urandom});
		// long slide clears the whole window
		issue(FUNC_SLIDE, 100, '0);
		issue(FUNC_SETCUR, 100, '0);
		issue(FUNC_REMOVE, 101, '0);
	endtask

	task automatic random_item();
		int unsigned      n;
		int unsigned      r;
		logic [SEQ_W-1:0] s;
		logic [FUNC_W-1:0] f;
		n = slots_in_use();
		r = $urandom_range(0, 99);
		s = lower_seq + $urandom_range(0, n - 1);
		f = FUNC_STORE;
		if (r < 35) f = FUNC_STORE;
		else if (r < 50) f = FUNC_READ;
		else if (r < 62) f = FUNC_REMOVE;
		else if (r < 75) begin
			f = FUNC_SLIDE;
			s = lower_seq + (($urandom_range(0, 4) == 0) ? $urandom_range(n, 3 * n)
				: $urandom_range(1, n));
		end else if (r < 82) begin
			f = FUNC_SETCUR;
			s = lower_seq + $urandom_range(0, n + 2);
		end else if (r < 88) begin
			// noise over the full field ranges
			f = FUNC_W'($urandom);
			s = $urandom;
		end else if (r < 93) begin
			f = FUNC_SLIDE;
			s = lower_seq - $urandom_range(0, 2 * n);
		end else begin
			f = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
			s = $urandom;
		end
		issue(f, s, {$urandom, $urandom});
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] sizes [8];
		sizes = '{CFG_W'(8), CFG_W'(1), CFG_W'(32), CFG_W'(0), CFG_W'(63), CFG_W'(3),
			CFG_W'(33), CFG_W'($urandom_range(0, 63))};
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		for (int phase = 0; phase < 8; phase++) begin
			// size changes only once every item has come back
			drain();
			write_size(sizes[phase]);
			no_gaps = (phase == 2 || phase == 5);
			if (phase == 0) directed_items();
			repeat (50) random_item();
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
